// File: rtl/gtvi_pkg.sv
// Shared constants, offset tables, stage record and divider step for the vertex index core.
package gtvi_pkg;

   localparam int MAX_GRID_SIZE  = 256;
   localparam int GRID_W         = 9;
   localparam int NUM_W          = 27;
   localparam int CELL_W         = 25;
   localparam int VERTEX_W       = 25;
   localparam int SLOT_W         = 3;
   localparam int TETRA_PER_CELL = 6;
   localparam int NUM_VERTS      = 4;
   localparam int BITS_PER_STAGE = 5;
   localparam int DIV_STAGES     = CELL_W / BITS_PER_STAGE;
   localparam int DIV_TOTAL      = 3 * DIV_STAGES;
   localparam int GG_W           = 2 * GRID_W - 1;

   // num / 6 == (num * RECIP6) >> RECIP_SHIFT for every 27-bit num
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 28;
   localparam logic [RECIP_W-1:0] RECIP6 = 28'd178956971;
   localparam int PROD_W = NUM_W + RECIP_W;

   localparam logic [GRID_W-1:0] GRID_RESET = 9'd64;
   localparam logic [GRID_W-1:0] GRID_MAX   = GRID_W'(MAX_GRID_SIZE);

   // bit s of each entry is the offset for slot s; entries are vertices a..d
   localparam logic [TETRA_PER_CELL-1:0] OFF_I [NUM_VERTS] =
      '{6'b000000, 6'b111000, 6'b111110, 6'b110011};
   localparam logic [TETRA_PER_CELL-1:0] OFF_J [NUM_VERTS] =
      '{6'b111000, 6'b000111, 6'b111000, 6'b011100};
   localparam logic [TETRA_PER_CELL-1:0] OFF_K [NUM_VERTS] =
      '{6'b000100, 6'b111100, 6'b011111, 6'b001001};

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [GRID_W-1:0] ci;
      logic [GRID_W-1:0] cj;
      logic [GRID_W-1:0] rem;
      logic [CELL_W-1:0] work;
   } gtvi_item_type;

   // a few restoring-division steps: rem:work shifts left, quotient bits enter work
   function automatic logic [GRID_W+CELL_W-1:0] div_steps(
      input logic [GRID_W-1:0] rem,
      input logic [CELL_W-1:0] work,
      input logic [GRID_W-1:0] g
   );
      logic [GRID_W-1:0] r;
      logic [CELL_W-1:0] w;
      logic [GRID_W:0]   t;
      r = rem;
      w = work;
      for (int n = 0; n < BITS_PER_STAGE; n++) begin
         t = {r, w[CELL_W-1]};
         w = {w[CELL_W-2:0], 1'b0};
         if (t >= {1'b0, g}) begin
            t = t - {1'b0, g};
            w[0] = 1'b1;
         end
         r = t[GRID_W-1:0];
      end
      return {r, w};
   endfunction

endpackage

// File: rtl/gtvi_div_pipe.sv
// Pipelined divider chain: cell -> i, j, k coordinates modulo the grid size.
module gtvi_div_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic [gtvi_pkg::GRID_W-1:0] grid,
   input  logic                   in_valid,
   input  gtvi_pkg::gtvi_item_type in_item,
   output logic                   out_valid,
   output gtvi_pkg::gtvi_item_type out_item
);
   import gtvi_pkg::*;

   logic          valid_ff [DIV_TOTAL];
   gtvi_item_type st_ff    [DIV_TOTAL];
   gtvi_item_type st_in    [DIV_TOTAL];

   for (genvar s = 0; s < DIV_TOTAL; s++) begin : g_stage
      gtvi_item_type prev;
      logic [GRID_W+CELL_W-1:0] res;

      assign prev = (s == 0) ? in_item : st_ff[(s == 0) ? 0 : s - 1];
      assign res  = div_steps(prev.rem, prev.work, grid);

      always_comb begin
         st_in[s]      = prev;
         st_in[s].rem  = res[GRID_W+CELL_W-1:CELL_W];
         st_in[s].work = res[CELL_W-1:0];
         // end of a division: park the remainder, restart on the quotient
         if (s == DIV_STAGES - 1) begin
            st_in[s].ci  = res[GRID_W+CELL_W-1:CELL_W];
            st_in[s].rem = '0;
         end else if (s == 2 * DIV_STAGES - 1) begin
            st_in[s].cj  = res[GRID_W+CELL_W-1:CELL_W];
            st_in[s].rem = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s - 1];
         end
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_TOTAL-1];
   assign out_item  = st_ff[DIV_TOTAL-1];

endmodule

// File: rtl/grid_tetrahedron_vertex_index_core.sv
// Top level: tetrahedron number to four grid vertex indices, fully pipelined.
//
//   channel   direction   ports                              handshake
//   req       in          req_tetra_number                   req_valid / req_stall
//   rsp       out         rsp_vertex_a .. rsp_vertex_d       rsp_valid / rsp_stall
//   csr       in          csr_wr_data (grid size)            csr_wr_en
//
// One word per cycle in and out while the output is not stalled. Stages in order: the split by six,
// three chained divisions by the grid size (five quotient bits per stage), then offsets, products
// and the final sum, the last being the output register.
// Synchronous reset clears all valid bits and sets the grid size to 64.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module grid_tetrahedron_vertex_index_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gtvi_pkg::NUM_W-1:0]      req_tetra_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gtvi_pkg::VERTEX_W-1:0]   rsp_vertex_a,
   output logic [gtvi_pkg::VERTEX_W-1:0]   rsp_vertex_b,
   output logic [gtvi_pkg::VERTEX_W-1:0]   rsp_vertex_c,
   output logic [gtvi_pkg::VERTEX_W-1:0]   rsp_vertex_d,
   input  logic                            csr_wr_en,
   input  logic [gtvi_pkg::GRID_W-1:0]     csr_wr_data
);
   import gtvi_pkg::*;

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // grid size, clamped to 1..MAX_GRID_SIZE
   logic [GRID_W-1:0] csr_ff, g_ff, g_in;
   logic [GG_W-1:0]   gg_ff;
   logic [2*GRID_W-1:0] gg_full;

   always_comb begin
      g_in = csr_ff;
      if (csr_ff == '0) g_in = GRID_W'(1);
      else if (csr_ff > GRID_MAX) g_in = GRID_MAX;
   end
   assign gg_full = g_ff * g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= GRID_RESET;
         g_ff   <= GRID_RESET;
         gg_ff  <= GG_W'(GRID_RESET) * GG_W'(GRID_RESET);
      end else begin
         if (csr_wr_en) csr_ff <= csr_wr_data;
         g_ff  <= g_in;
         gg_ff <= gg_full[GG_W-1:0];
      end
   end

   // split by six: reciprocal product, then cell and slot
   logic              m_valid_ff, c_valid_ff;
   logic [PROD_W-1:0] m_prod_ff;
   logic [NUM_W-1:0]  m_num_ff;
   logic [CELL_W-1:0] cell_num;
   logic [NUM_W-1:0]  slot_full;
   gtvi_item_type     c_item_ff, c_item_in;

   assign cell_num  = m_prod_ff[RECIP_SHIFT +: CELL_W];
   assign slot_full = m_num_ff - ({2'b00, cell_num} * NUM_W'(TETRA_PER_CELL));

   always_comb begin
      c_item_in      = '0;
      c_item_in.slot = slot_full[SLOT_W-1:0];
      c_item_in.work = cell_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= req_valid;
         c_valid_ff <= m_valid_ff;
      end
      if (adv) begin
         m_prod_ff <= PROD_W'(req_tetra_number) * PROD_W'(RECIP6);
         m_num_ff  <= req_tetra_number;
         c_item_ff <= c_item_in;
      end
   end

   logic          d_valid;
   gtvi_item_type d_item;

   gtvi_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .grid      (g_ff),
      .in_valid  (c_valid_ff),
      .in_item   (c_item_ff),
      .out_valid (d_valid),
      .out_item  (d_item)
   );

   // offsets with periodic wrap on i and j; k is open-ended
   logic              f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic [GRID_W-1:0] f1_x_ff [NUM_VERTS];
   logic [GRID_W-1:0] f1_y_ff [NUM_VERTS];
   logic [GRID_W-1:0] f1_z_ff [NUM_VERTS];
   logic [GRID_W-1:0] f1_x_in [NUM_VERTS];
   logic [GRID_W-1:0] f1_y_in [NUM_VERTS];
   logic [GRID_W-1:0] f1_z_in [NUM_VERTS];
   logic [GRID_W-1:0]    f2_x_ff  [NUM_VERTS];
   logic [2*GRID_W-1:0]  f2_yg_ff [NUM_VERTS];
   logic [GRID_W+GG_W-1:0] f2_zg_ff [NUM_VERTS];
   logic [VERTEX_W-1:0]  f3_v_ff  [NUM_VERTS];
   logic [GRID_W+GG_W:0] sum_in   [NUM_VERTS];

   always_comb begin
      for (int v = 0; v < NUM_VERTS; v++) begin
         f1_x_in[v] = d_item.ci + GRID_W'(OFF_I[v][d_item.slot]);
         f1_y_in[v] = d_item.cj + GRID_W'(OFF_J[v][d_item.slot]);
         f1_z_in[v] = d_item.rem + GRID_W'(OFF_K[v][d_item.slot]);
         if (f1_x_in[v] == g_ff) f1_x_in[v] = '0;
         if (f1_y_in[v] == g_ff) f1_y_in[v] = '0;
         sum_in[v] = (GRID_W+GG_W+1)'(f2_x_ff[v]) + (GRID_W+GG_W+1)'(f2_yg_ff[v])
                   + (GRID_W+GG_W+1)'(f2_zg_ff[v]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= d_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
      if (adv) begin
         for (int v = 0; v < NUM_VERTS; v++) begin
            f1_x_ff[v]  <= f1_x_in[v];
            f1_y_ff[v]  <= f1_y_in[v];
            f1_z_ff[v]  <= f1_z_in[v];
            f2_x_ff[v]  <= f1_x_ff[v];
            f2_yg_ff[v] <= f1_y_ff[v] * g_ff;
            f2_zg_ff[v] <= (GRID_W+GG_W)'(f1_z_ff[v]) * (GRID_W+GG_W)'(gg_ff);
            f3_v_ff[v]  <= sum_in[v][VERTEX_W-1:0];
         end
      end
   end

   assign rsp_valid    = f3_valid_ff;
   assign rsp_vertex_a = f3_v_ff[0];
   assign rsp_vertex_b = f3_v_ff[1];
   assign rsp_vertex_c = f3_v_ff[2];
   assign rsp_vertex_d = f3_v_ff[3];

endmodule
